[rtl/core/aat_pkg.sv]
// shared types, constants and saturating arithmetic for the box transform unit
package aat_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int NUM_AXES    = 3;
    localparam int NUM_STAGES  = 5;
    localparam int CFG_IDX_W   = 3;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef t_coord [NUM_AXES-1:0]         t_coord3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_reg_idx;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // input beat: row-major matrix then translation
    typedef struct packed {
        t_coord coef_r0_c0;
        t_coord coef_r0_c1;
        t_coord coef_r0_c2;
        t_coord coef_r1_c0;
        t_coord coef_r1_c1;
        t_coord coef_r1_c2;
        t_coord coef_r2_c0;
        t_coord coef_r2_c1;
        t_coord coef_r2_c2;
        t_coord shift_x;
        t_coord shift_y;
        t_coord shift_z;
    } t_in_beat;

    // output beat: transformed box
    typedef struct packed {
        t_coord new_min_x;
        t_coord new_min_y;
        t_coord new_min_z;
        t_coord new_max_x;
        t_coord new_max_y;
        t_coord new_max_z;
    } t_out_beat;

    // per-stage load enables shared by all lanes
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_stage_ctl;

    // floor shift of a full product, clamped to the coordinate range
    function automatic t_coord clamp_prod(input t_prod p);
        t_prod q;
        q = p >>> FRAC_BITS;
        if (&q[PROD_WIDTH-1:COORD_WIDTH-1] || ~|q[PROD_WIDTH-1:COORD_WIDTH-1]) begin
            return q[COORD_WIDTH-1:0];
        end
        return q[PROD_WIDTH-1] ? COORD_MIN : COORD_MAX;
    endfunction

    // saturating add of two coordinates
    function automatic t_coord sat_add(input t_coord a, input t_coord b);
        logic signed [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
            return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
        end
        return s[COORD_WIDTH-1:0];
    endfunction

endpackage

[rtl/core/aabb_affine_transform_unit.sv]
// affine transform of an axis-aligned box, fixed point, five-stage pipeline
//
// usage:
//   config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) loads
//   the original box: indexes 0..2 are min x/y/z, 3..5 are max x/y/z; other
//   indexes are dropped. o_cfg_ready is always high. write only while idle.
//   input channel (i_in_valid / o_in_stall, i_in_beat) carries a 3x3 matrix in
//   row-vector convention and a translation; output channel (o_out_valid /
//   i_out_stall, o_out_beat) returns the enclosing transformed box.
//   a beat moves at a clock edge with valid high and stall low.
// timing:
//   an input beat passes five registered stages: multiply, clamp and order, then
//   one saturating add per source axis. throughput is one beat per cycle while the
//   output is not stalled, set by the 18 parallel 32x32 multipliers feeding the stage chain.
// reset:
//   synchronous, active low; clears all stage valid bits and the box registers.
// stall:
//   a stalled output holds its beat; upstream stages keep advancing into empty
//   slots, and o_in_stall rises only once every stage holds a beat.
module aabb_affine_transform_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [aat_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  aat_pkg::t_coord                     i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  aat_pkg::t_in_beat                   i_in_beat,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output aat_pkg::t_out_beat                  o_out_beat
);

    aat_pkg::t_coord3                      r_box_min, r_box_max;
    logic [aat_pkg::NUM_STAGES-1:0]        r_vld;
    logic [aat_pkg::NUM_STAGES-1:0]        w_ready;
    aat_pkg::t_stage_ctl                   w_ctl;
    aat_pkg::t_coord3                      w_coef [aat_pkg::NUM_AXES];
    aat_pkg::t_coord3                      w_shift;
    aat_pkg::t_coord                       w_lo [aat_pkg::NUM_AXES];
    aat_pkg::t_coord                       w_hi [aat_pkg::NUM_AXES];

    assign o_cfg_ready = 1'b1;

    // box register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min <= '0;
            r_box_max <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                aat_pkg::REG_MIN_X: r_box_min[0] <= i_cfg_data;
                aat_pkg::REG_MIN_Y: r_box_min[1] <= i_cfg_data;
                aat_pkg::REG_MIN_Z: r_box_min[2] <= i_cfg_data;
                aat_pkg::REG_MAX_X: r_box_max[0] <= i_cfg_data;
                aat_pkg::REG_MAX_Y: r_box_max[1] <= i_cfg_data;
                aat_pkg::REG_MAX_Z: r_box_max[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage ready chain: a stage loads when empty or when it drains
    always_comb begin
        w_ready[aat_pkg::NUM_STAGES-1] = !r_vld[aat_pkg::NUM_STAGES-1] || !i_out_stall;
        for (int k = aat_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            w_ready[k] = !r_vld[k] || w_ready[k+1];
        end
        w_ctl.load = w_ready;
    end

    assign o_in_stall = !w_ready[0];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ready[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < aat_pkg::NUM_STAGES; k++) begin
                if (w_ready[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // matrix columns per output axis: w_coef[j][i] is row i, column j
    assign w_coef[0] = {i_in_beat.coef_r2_c0, i_in_beat.coef_r1_c0, i_in_beat.coef_r0_c0};
    assign w_coef[1] = {i_in_beat.coef_r2_c1, i_in_beat.coef_r1_c1, i_in_beat.coef_r0_c1};
    assign w_coef[2] = {i_in_beat.coef_r2_c2, i_in_beat.coef_r1_c2, i_in_beat.coef_r0_c2};
    assign w_shift   = {i_in_beat.shift_z, i_in_beat.shift_y, i_in_beat.shift_x};

    // one lane per output axis
    for (genvar j = 0; j < aat_pkg::NUM_AXES; j++) begin : g_lane
        aat_lane u_lane (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_coef    (w_coef[j]),
            .i_shift   (w_shift[j]),
            .i_box_min (r_box_min),
            .i_box_max (r_box_max),
            .o_lo      (w_lo[j]),
            .o_hi      (w_hi[j])
        );
    end

    assign o_out_valid          = r_vld[aat_pkg::NUM_STAGES-1];
    assign o_out_beat.new_min_x = w_lo[0];
    assign o_out_beat.new_min_y = w_lo[1];
    assign o_out_beat.new_min_z = w_lo[2];
    assign o_out_beat.new_max_x = w_hi[0];
    assign o_out_beat.new_max_y = w_hi[1];
    assign o_out_beat.new_max_z = w_hi[2];

`ifndef SYNTH
    // reset empties the whole pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");

    // input is pushed back only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> &r_vld)
        else $error("input stalled with a free stage");

    // an accepted beat lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[0])
        else $error("accepted beat lost at stage 1");

    // a held stage keeps its beat when the next one cannot take it
    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !w_ready[4]) |=> r_vld[3] && r_vld[4])
        else $error("beat dropped under stall");
`endif

endmodule

[rtl/core/aat_lane.sv]
// one output axis: products, ordering and three saturating accumulations
module aat_lane (
    input  logic                i_clk,
    input  aat_pkg::t_stage_ctl i_ctl,
    input  aat_pkg::t_coord3    i_coef,
    input  aat_pkg::t_coord     i_shift,
    input  aat_pkg::t_coord3    i_box_min,
    input  aat_pkg::t_coord3    i_box_max,
    output aat_pkg::t_coord     o_lo,
    output aat_pkg::t_coord     o_hi
);

    // stage 1 registers
    aat_pkg::t_prod  r_p_min [aat_pkg::NUM_AXES];
    aat_pkg::t_prod  r_p_max [aat_pkg::NUM_AXES];
    aat_pkg::t_coord r_t1;
    // stage 2 registers
    aat_pkg::t_coord r_lo_term2 [aat_pkg::NUM_AXES];
    aat_pkg::t_coord r_hi_term2 [aat_pkg::NUM_AXES];
    aat_pkg::t_coord r_t2;
    // stage 3 registers
    aat_pkg::t_coord r_lo3, r_hi3;
    aat_pkg::t_coord r_lo_term3 [2];
    aat_pkg::t_coord r_hi_term3 [2];
    // stage 4 registers
    aat_pkg::t_coord r_lo4, r_hi4;
    aat_pkg::t_coord r_lo_term4, r_hi_term4;
    // stage 5 registers
    aat_pkg::t_coord r_lo5, r_hi5;

    aat_pkg::t_coord n_lo_term [aat_pkg::NUM_AXES];
    aat_pkg::t_coord n_hi_term [aat_pkg::NUM_AXES];

    // stage 1: full-width products against the box bounds
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            for (int i = 0; i < aat_pkg::NUM_AXES; i++) begin
                r_p_min[i] <= aat_pkg::t_prod'(i_coef[i]) * aat_pkg::t_prod'(i_box_min[i]);
                r_p_max[i] <= aat_pkg::t_prod'(i_coef[i]) * aat_pkg::t_prod'(i_box_max[i]);
            end
            r_t1 <= i_shift;
        end
    end

    // stage 2 logic: floor shift, clamp and order each product pair
    always_comb begin
        aat_pkg::t_coord a, b;
        for (int i = 0; i < aat_pkg::NUM_AXES; i++) begin
            a = aat_pkg::clamp_prod(r_p_min[i]);
            b = aat_pkg::clamp_prod(r_p_max[i]);
            if (a < b) begin
                n_lo_term[i] = a;
                n_hi_term[i] = b;
            end else begin
                n_lo_term[i] = b;
                n_hi_term[i] = a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_lo_term2 <= n_lo_term;
            r_hi_term2 <= n_hi_term;
            r_t2       <= r_t1;
        end
    end

    // stage 3: translation plus source axis x
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_lo3         <= aat_pkg::sat_add(r_t2, r_lo_term2[0]);
            r_hi3         <= aat_pkg::sat_add(r_t2, r_hi_term2[0]);
            r_lo_term3[0] <= r_lo_term2[1];
            r_lo_term3[1] <= r_lo_term2[2];
            r_hi_term3[0] <= r_hi_term2[1];
            r_hi_term3[1] <= r_hi_term2[2];
        end
    end

    // stage 4: source axis y
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_lo4      <= aat_pkg::sat_add(r_lo3, r_lo_term3[0]);
            r_hi4      <= aat_pkg::sat_add(r_hi3, r_hi_term3[0]);
            r_lo_term4 <= r_lo_term3[1];
            r_hi_term4 <= r_hi_term3[1];
        end
    end

    // stage 5: source axis z, output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r_lo5 <= aat_pkg::sat_add(r_lo4, r_lo_term4);
            r_hi5 <= aat_pkg::sat_add(r_hi4, r_hi_term4);
        end
    end

    assign o_lo = r_lo5;
    assign o_hi = r_hi5;

endmodule

[test/aat_box_checker.sv]
// box transform checker: watches the config, input and output channels and scores each result
`timescale 1ns / 1ps

module aat_box_checker
    import aat_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_coord               i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_beat             i_in_beat,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_beat            i_out_beat,
    output int                   o_err_cnt,
    output int                   o_pending
);

    localparam longint SAT_HI    = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO    = -64'sh0000_0000_8000_0000;

    // shadow copy of the original box
    t_coord    box_lo [3];
    t_coord    box_hi [3];
    t_out_beat box_q [$];
    int        err_total = 0;

    assign o_err_cnt = err_total;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_total++;
    endtask

    function automatic longint clip_coord(input longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    // exact product, floor of the fraction drop, then clip
    function automatic longint q_mul_floor(input t_coord m, input t_coord v);
        longint p;
        p = longint'(m) * longint'(v);
        return clip_coord(p >>> FRAC_BITS);
    endfunction

    // enclosing box of the original box under p*M + T
    function automatic t_out_beat enclose_xformed(input t_in_beat b);
        t_coord    mat [3][3];
        t_coord    shift [3];
        t_coord    res_lo [3];
        t_coord    res_hi [3];
        longint    lo;
        longint    hi;
        longint    pa;
        longint    pb;
        t_out_beat r;
        mat[0][0] = b.coef_r0_c0; mat[0][1] = b.coef_r0_c1; mat[0][2] = b.coef_r0_c2;
        mat[1][0] = b.coef_r1_c0; mat[1][1] = b.coef_r1_c1; mat[1][2] = b.coef_r1_c2;
        mat[2][0] = b.coef_r2_c0; mat[2][1] = b.coef_r2_c1; mat[2][2] = b.coef_r2_c2;
        shift[0] = b.shift_x;
        shift[1] = b.shift_y;
        shift[2] = b.shift_z;
        for (int j = 0; j < 3; j++) begin
            lo = longint'(shift[j]);
            hi = lo;
            for (int i = 0; i < 3; i++) begin
                pa = q_mul_floor(mat[i][j], box_lo[i]);
                pb = q_mul_floor(mat[i][j], box_hi[i]);
                // smaller product feeds the min, larger the max
                if (pa < pb) begin
                    lo = clip_coord(lo + pa);
                    hi = clip_coord(hi + pb);
                end else begin
                    lo = clip_coord(lo + pb);
                    hi = clip_coord(hi + pa);
                end
            end
            res_lo[j] = t_coord'(lo);
            res_hi[j] = t_coord'(hi);
        end
        r.new_min_x = res_lo[0];
        r.new_min_y = res_lo[1];
        r.new_min_z = res_lo[2];
        r.new_max_x = res_hi[0];
        r.new_max_y = res_hi[1];
        r.new_max_z = res_hi[2];
        return r;
    endfunction

    task automatic check_field(input string name, input t_coord got, input t_coord want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // channel monitor
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                box_lo[k] = '0;
                box_hi[k] = '0;
            end
            box_q.delete();
        end else begin
            // register writes, spare indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MIN_X: box_lo[0] = i_cfg_data;
                    REG_MIN_Y: box_lo[1] = i_cfg_data;
                    REG_MIN_Z: box_lo[2] = i_cfg_data;
                    REG_MAX_X: box_hi[0] = i_cfg_data;
                    REG_MAX_Y: box_hi[1] = i_cfg_data;
                    REG_MAX_Z: box_hi[2] = i_cfg_data;
                    default: ;
                endcase
            end
            // output beat against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (box_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", i_out_beat));
                end else begin
                    want = box_q.pop_front();
                    check_field("new_min_x", i_out_beat.new_min_x, want.new_min_x);
                    check_field("new_min_y", i_out_beat.new_min_y, want.new_min_y);
                    check_field("new_min_z", i_out_beat.new_min_z, want.new_min_z);
                    check_field("new_max_x", i_out_beat.new_max_x, want.new_max_x);
                    check_field("new_max_y", i_out_beat.new_max_y, want.new_max_y);
                    check_field("new_max_z", i_out_beat.new_max_z, want.new_max_z);
                end
            end
            // accepted input beat
            if (i_in_valid && !i_in_stall) begin
                box_q.push_back(enclose_xformed(i_in_beat));
            end
        end
        o_pending <= box_q.size();
    end

endmodule

[test/tb.sv]
// top of the box transform testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import aat_pkg::*;

    localparam int     CYCLE_LIMIT     = 400000;
    localparam int     ITEMS_PER_PHASE = 144;
    localparam int     NUM_PHASES      = 8;
    localparam int     LONG_HOLD       = 60;
    localparam int     SETTLE_CYCLES   = NUM_STAGES + 3;
    localparam t_coord ONE_Q           = 32'sh0001_0000;
    localparam t_coord NEG_ONE_Q       = -32'sh0001_0000;
    localparam t_coord HALF_Q          = 32'sh0000_8000;
    localparam t_coord ULP             = 32'sd1;
    localparam t_coord NEG_ULP         = -32'sd1;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    t_coord               cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_beat             in_beat   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_beat            out_beat;

    int err_cnt;
    int pending;
    int cycle_cnt     = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asked    = 0;
    int hold_taken    = 0;
    int hold_left     = 0;

    aabb_affine_transform_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    aat_box_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_beat  (out_beat),
        .o_err_cnt   (err_cnt),
        .o_pending   (pending)
    );

    always #10 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL aabb_affine_transform_unit");
            $finish;
        end
    end

    // receiver: random stall, or a long hold when one is asked for
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_coord near_zero(input int unsigned span);
        return t_coord'($urandom_range(0, 2 * span)) - t_coord'(span);
    endfunction

    // full-range value with extra weight on the edges
    function automatic t_coord pick_coord();
        case ($urandom_range(9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return $urandom_range(1) ? ULP : NEG_ULP;
            4: return $urandom_range(1) ? ONE_Q : NEG_ONE_Q;
            5: return near_zero(32'h0008_0000);
            default: return t_coord'($urandom());
        endcase
    endfunction

    function automatic t_in_beat rand_xform(input bit wild);
        t_coord f [12];
        for (int k = 0; k < 12; k++) begin
            if (wild || $urandom_range(19) == 0) begin
                f[k] = pick_coord();
            end else begin
                f[k] = (k < 9) ? near_zero(32'h0002_0000) : near_zero(32'h0010_0000);
            end
        end
        return {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]};
    endfunction

    function automatic t_in_beat uniform_xform(input t_coord diag, input t_coord off,
                                               input t_coord sh);
        return {diag, off, off, off, diag, off, off, off, diag, sh, sh, sh};
    endfunction

    task automatic offer_xform(input t_in_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_coord v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_box(input t_coord lo_x, input t_coord lo_y, input t_coord lo_z,
                            input t_coord hi_x, input t_coord hi_y, input t_coord hi_z,
                            input bit spare);
        settle_pipe();
        write_reg(REG_MIN_X, lo_x);
        write_reg(REG_MIN_Y, lo_y);
        write_reg(REG_MIN_Z, lo_z);
        write_reg(REG_MAX_X, hi_x);
        write_reg(REG_MAX_Y, hi_y);
        write_reg(REG_MAX_Z, hi_z);
        // spare indexes must leave the box alone
        if (spare) begin
            write_reg(IDX_SPARE_LO, t_coord'($urandom()));
            write_reg(IDX_SPARE_HI, t_coord'($urandom()));
        end
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        t_coord lo [3];
        t_coord hi [3];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // box still at its reset value
        offer_xform(rand_xform(1'b1));

        // ordinary box
        load_box(32'shFFFA_8000, 32'shFFFE_0000, ONE_Q,
                 32'sh0003_4000, 32'sh0007_0000, 32'sh0009_0000, 1'b1);
        offer_xform(uniform_xform(ONE_Q, '0, '0));
        offer_xform(uniform_xform('0, '0, '0));
        offer_xform(uniform_xform(COORD_MAX, COORD_MAX, '0));
        offer_xform(uniform_xform(COORD_MIN, COORD_MIN, '0));
        offer_xform(uniform_xform(NEG_ULP, NEG_ULP, '0));
        offer_xform(uniform_xform(ULP, ULP, '0));
        offer_xform(uniform_xform(NEG_ONE_Q, '0, 32'sh0003_0000));
        offer_xform(uniform_xform(ONE_Q, ONE_Q, COORD_MAX));
        offer_xform(uniform_xform(NEG_ONE_Q, NEG_ONE_Q, COORD_MIN));
        offer_xform({t_coord'('0), NEG_ONE_Q, t_coord'('0),
                     t_coord'('0), t_coord'('0), ONE_Q,
                     ONE_Q, t_coord'('0), t_coord'('0),
                     HALF_Q, NEG_ULP, ULP});
        offer_xform(uniform_xform(HALF_Q, -HALF_Q, NEG_ULP));

        // widest box: product and sum saturation
        load_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        offer_xform(uniform_xform(ONE_Q, '0, '0));
        offer_xform(uniform_xform(COORD_MAX, COORD_MAX, COORD_MAX));
        offer_xform(uniform_xform(COORD_MIN, COORD_MIN, COORD_MIN));
        offer_xform(uniform_xform(NEG_ULP, ULP, '0));
        offer_xform(uniform_xform(COORD_MIN, '0, COORD_MAX));

        // inverted box, min above max
        load_box(32'sh0009_0000, 32'sh0007_0000, 32'sh0003_4000,
                 32'shFFFA_8000, 32'shFFFE_0000, ONE_Q, 1'b1);
        offer_xform(uniform_xform(ONE_Q, '0, '0));
        offer_xform(uniform_xform(NEG_ONE_Q, HALF_Q, ULP));
        offer_xform(rand_xform(1'b1));

        // flat box, every product pair equal
        load_box(32'shFFFD_0000, 32'shFFFD_0000, 32'shFFFD_0000,
                 32'shFFFD_0000, 32'shFFFD_0000, 32'shFFFD_0000, 1'b0);
        offer_xform(uniform_xform(ONE_Q, NEG_ONE_Q, '0));
        offer_xform(uniform_xform(COORD_MAX, COORD_MIN, COORD_MIN));

        // random phases, each with its own box and idling pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            for (int k = 0; k < 3; k++) begin
                if (p == 0) begin
                    lo[k] = COORD_MIN;
                    hi[k] = COORD_MAX;
                end else if (p == 1) begin
                    lo[k] = COORD_MAX;
                    hi[k] = COORD_MIN;
                end else if (p % 2 == 1) begin
                    lo[k] = pick_coord();
                    hi[k] = pick_coord();
                end else begin
                    lo[k] = near_zero(32'h0010_0000);
                    hi[k] = lo[k] + t_coord'($urandom_range(0, 32'h000A_0000));
                end
            end
            load_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], p % 3 == 0);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 65; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 65; end
                default: begin send_idle_pct = 18; stall_pct = 18; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long output hold while the input keeps coming
                if (p == 4 && n == 30) hold_asked++;
                // pause the input until everything has come back
                if (p == 5 && n == 60) begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
                offer_xform(rand_xform($urandom_range(3) == 0));
            end
        end

        settle_pipe();
        repeat (2 * NUM_STAGES) @(posedge clk);
        if (err_cnt == 0) begin
            $display("PASS aabb_affine_transform_unit");
        end else begin
            $display("FAIL aabb_affine_transform_unit");
        end
        $finish;
    end

endmodule
